### rtl/core/jss_pkg.sv
// Shared types and constants for the Jacobi five-point stencil sweep.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package jss_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned MAX_COLS_DEF  = 512;
  localparam int unsigned MAX_ROWS_DEF  = 512;
  localparam int unsigned TEMP_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned SIZE_W  = 10;  // cols_in_use / rows_in_use
  localparam int unsigned EPS_W   = 16;  // epsilon
  localparam int unsigned CHG_W   = 16;  // max_change
  localparam int unsigned IDX_W   = 9;   // row_index / col_index
  localparam int unsigned CFG_DW  = 16;  // widest config register
  localparam int unsigned CFG_AW  = 2;

  // Register reset values
  localparam int unsigned SIZE_RST = 512;
  localparam int unsigned EPS_RST  = 1;

  // Smallest grid side the stencil accepts
  localparam int unsigned SIZE_MIN = 3;

  // Mean of four neighbors: divide by 4.0 is a shift by two
  localparam int unsigned AVG_SHIFT = 2;

  typedef enum logic [CFG_AW-1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_EPS  = 2'd2
  } cfg_idx_e;

endpackage

### rtl/core/jss_cfg.sv
// Configuration registers: grid size (stored as clamped last index) and epsilon.
// Depends on jss_pkg.
`timescale 1ns / 1ps

module jss_cfg #(
  parameter int unsigned MAX_COLS = jss_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = jss_pkg::MAX_ROWS_DEF,
  localparam int unsigned COL_W   = $clog2(MAX_COLS),
  localparam int unsigned ROW_W   = $clog2(MAX_ROWS)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [jss_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  logic [jss_pkg::CFG_DW-1:0]   cfg_wdata_i,
  output logic [COL_W-1:0]             cols_last_o,
  output logic [ROW_W-1:0]             rows_last_o,
  output logic [jss_pkg::EPS_W-1:0]    eps_o
);

  localparam int unsigned COLS_RST =
    (jss_pkg::SIZE_RST > MAX_COLS) ? MAX_COLS : jss_pkg::SIZE_RST;
  localparam int unsigned ROWS_RST =
    (jss_pkg::SIZE_RST > MAX_ROWS) ? MAX_ROWS : jss_pkg::SIZE_RST;

  // clamp into [SIZE_MIN, hi], return last index
  function automatic logic [31:0] last_idx(input logic [jss_pkg::SIZE_W-1:0] v,
                                           input logic [31:0] hi);
    logic [31:0] v32;
    logic [31:0] c;
    v32 = 32'(v);
    if (v32 < 32'(jss_pkg::SIZE_MIN)) c = 32'(jss_pkg::SIZE_MIN);
    else if (v32 > hi)                c = hi;
    else                              c = v32;
    return c - 32'd1;
  endfunction

  logic [COL_W-1:0]          cols_last_q, cols_last_d;
  logic [ROW_W-1:0]          rows_last_q, rows_last_d;
  logic [jss_pkg::EPS_W-1:0] eps_q, eps_d;
  logic [31:0]               cols_l32, rows_l32;

  assign cols_l32 = last_idx(cfg_wdata_i[jss_pkg::SIZE_W-1:0], 32'(MAX_COLS));
  assign rows_l32 = last_idx(cfg_wdata_i[jss_pkg::SIZE_W-1:0], 32'(MAX_ROWS));

  always_comb begin
    cols_last_d = cols_last_q;
    rows_last_d = rows_last_q;
    eps_d       = eps_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        jss_pkg::CFG_COLS: cols_last_d = cols_l32[COL_W-1:0];
        jss_pkg::CFG_ROWS: rows_last_d = rows_l32[ROW_W-1:0];
        jss_pkg::CFG_EPS:  eps_d       = cfg_wdata_i[jss_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_last_q <= COL_W'(COLS_RST - 1);
      rows_last_q <= ROW_W'(ROWS_RST - 1);
      eps_q       <= jss_pkg::EPS_W'(jss_pkg::EPS_RST);
    end else begin
      cols_last_q <= cols_last_d;
      rows_last_q <= rows_last_d;
      eps_q       <= eps_d;
    end
  end

  assign cols_last_o = cols_last_q;
  assign rows_last_o = rows_last_q;
  assign eps_o       = eps_q;

endmodule

### rtl/core/jss_linebuf.sv
// Two line buffers packed into one memory word {row two above, row above}.
// One write port, two registered read ports. Depends on jss_pkg.
`timescale 1ns / 1ps

module jss_linebuf #(
  parameter int unsigned MAX_COLS  = jss_pkg::MAX_COLS_DEF,
  parameter int unsigned TEMP_BITS = jss_pkg::TEMP_BITS_DEF,
  localparam int unsigned COL_W    = $clog2(MAX_COLS)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [COL_W-1:0]       waddr_i,
  input  logic [2*TEMP_BITS-1:0] wdata_i,
  input  logic                   re_i,
  input  logic [COL_W-1:0]       raddr_a_i,
  input  logic [COL_W-1:0]       raddr_b_i,
  output logic [2*TEMP_BITS-1:0] word_a_o,   // {two above, above} at port A
  output logic [TEMP_BITS-1:0]   above_b_o   // row above at port B
);

  logic [2*TEMP_BITS-1:0] mem_q [MAX_COLS];
  logic [2*TEMP_BITS-1:0] word_a_q;
  logic [TEMP_BITS-1:0]   above_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      word_a_q  <= mem_q[raddr_a_i];
      above_b_q <= mem_q[raddr_b_i][TEMP_BITS-1:0];
    end
  end

  assign word_a_o  = word_a_q;
  assign above_b_o = above_b_q;

endmodule

### rtl/core/jss_stencil.sv
// Five-point update: truncated mean, absolute change, running max, converged.
// Purely combinational. Depends on jss_pkg.
`timescale 1ns / 1ps

module jss_stencil #(
  parameter int unsigned TEMP_BITS = jss_pkg::TEMP_BITS_DEF
) (
  input  logic [TEMP_BITS-1:0]      north_i,
  input  logic [TEMP_BITS-1:0]      south_i,
  input  logic [TEMP_BITS-1:0]      west_i,
  input  logic [TEMP_BITS-1:0]      east_i,
  input  logic [TEMP_BITS-1:0]      center_i,
  input  logic                      interior_i,
  input  logic [TEMP_BITS-1:0]      rmax_i,
  input  logic [jss_pkg::EPS_W-1:0] eps_i,
  output logic [TEMP_BITS-1:0]      new_val_o,
  output logic [TEMP_BITS-1:0]      rmax_next_o,
  output logic [jss_pkg::CHG_W-1:0] chg_o,
  output logic                      conv_o
);

  logic [TEMP_BITS+1:0] sum;
  logic [TEMP_BITS-1:0] avg;
  logic [TEMP_BITS-1:0] diff;
  logic [31:0]          rmax32;

  assign sum = {2'b00, north_i} + {2'b00, south_i} + {2'b00, west_i} + {2'b00, east_i};
  assign avg = TEMP_BITS'(sum >> jss_pkg::AVG_SHIFT);
  assign diff = (avg > center_i) ? (avg - center_i) : (center_i - avg);

  assign new_val_o   = interior_i ? avg : center_i;
  assign rmax_next_o = (interior_i && (diff > rmax_i)) ? diff : rmax_i;

  // change is reported on a 16-bit field
  assign rmax32 = 32'(rmax_next_o);
  assign chg_o  = rmax32[jss_pkg::CHG_W-1:0];
  assign conv_o = (chg_o < eps_i);

endmodule

### rtl/core/jacobi_stencil_sweep.sv
// Top level of the streaming Jacobi five-point stencil sweep.
// Depends on jss_pkg, jss_cfg, jss_linebuf and jss_stencil.
`timescale 1ns / 1ps

// Cells of the old grid enter one beat per clock in raster order on the input
// channel; each cell of row 1 or later produces one result beat carrying the
// updated cell directly above it (row 0 only fills the line buffers, and the
// bottom row is never emitted). A beat is accepted every cycle whenever the
// output register is empty or being drained, so the sustained rate is one
// cell per cycle and a result appears on the output in the cycle after its
// cell is accepted. The single datapath stage between the line-buffer read
// registers and the output register holds the four-way add, shift,
// absolute change and running-max compare. The line buffers are one memory
// with two read ports, read one column ahead of the accepted cell, so no
// bubble appears at the end of a row. The memory is not cleared after reset;
// the first row of every sweep writes it before it is read. The largest
// interior change and the converged flag ride on the sweep's last beat and
// are zero on every other beat. Size and epsilon must be written only while
// no beat is in flight.

module jacobi_stencil_sweep #(
  parameter int unsigned MAX_COLS  = jss_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS  = jss_pkg::MAX_ROWS_DEF,
  parameter int unsigned TEMP_BITS = jss_pkg::TEMP_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [jss_pkg::CFG_AW-1:0]   cfg_idx_i,
  input  logic [jss_pkg::CFG_DW-1:0]   cfg_wdata_i,
  // cell input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [TEMP_BITS-1:0]         temp_in_i,
  // result output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [TEMP_BITS-1:0]         temp_out_o,
  output logic [jss_pkg::IDX_W-1:0]    row_index_o,
  output logic [jss_pkg::IDX_W-1:0]    col_index_o,
  output logic                         sweep_last_o,
  output logic [jss_pkg::CHG_W-1:0]    max_change_o,
  output logic                         converged_o
);

  localparam int unsigned COL_W = $clog2(MAX_COLS);
  localparam int unsigned ROW_W = $clog2(MAX_ROWS);

  // config
  logic [COL_W-1:0]          cols_last;
  logic [ROW_W-1:0]          rows_last;
  logic [jss_pkg::EPS_W-1:0] eps;

  jss_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cols_last_o (cols_last),
    .rows_last_o (rows_last),
    .eps_o       (eps)
  );

  // position and sweep state
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [TEMP_BITS-1:0] rmax_q, rmax_d;
  logic [TEMP_BITS-1:0] west_q;

  logic in_fire;
  logic emit;
  logic end_row;
  logic end_sweep;
  logic interior;

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit       = (row_q != '0);

  // shrinking the size mid-sweep ends the row/sweep at the current cell
  assign end_row   = (col_q >= cols_last);
  assign end_sweep = end_row && (row_q >= rows_last);
  assign interior  = (row_q >= ROW_W'(2)) && (col_q != '0) && (col_q < cols_last);

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    if (in_fire) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_sweep ? '0 : (row_q + ROW_W'(1));
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // line buffers: read one column ahead, on the accepting edge
  logic [COL_W:0]         next_b_wide;
  logic [COL_W-1:0]       raddr_b;
  logic [2*TEMP_BITS-1:0] word_a;
  logic [TEMP_BITS-1:0]   east;
  logic [TEMP_BITS-1:0]   center;
  logic [TEMP_BITS-1:0]   north;

  // east of the last column is never used; saturate the address
  assign next_b_wide = {1'b0, col_d} + (COL_W + 1)'(1);
  assign raddr_b     = (next_b_wide >= (COL_W + 1)'(MAX_COLS)) ?
                       COL_W'(MAX_COLS - 1) : next_b_wide[COL_W-1:0];

  jss_linebuf #(
    .MAX_COLS  (MAX_COLS),
    .TEMP_BITS (TEMP_BITS)
  ) u_linebuf (
    .clk_i     (clk_i),
    .we_i      (in_fire),
    .waddr_i   (col_q),
    .wdata_i   ({center, temp_in_i}),
    .re_i      (in_fire),
    .raddr_a_i (col_d),
    .raddr_b_i (raddr_b),
    .word_a_o  (word_a),
    .above_b_o (east)
  );

  assign center = word_a[TEMP_BITS-1:0];
  assign north  = word_a[2*TEMP_BITS-1:TEMP_BITS];

  // stencil datapath
  logic [TEMP_BITS-1:0]      new_val;
  logic [TEMP_BITS-1:0]      rmax_next;
  logic [jss_pkg::CHG_W-1:0] chg;
  logic                      conv;

  jss_stencil #(
    .TEMP_BITS (TEMP_BITS)
  ) u_stencil (
    .north_i     (north),
    .south_i     (temp_in_i),
    .west_i      (west_q),
    .east_i      (east),
    .center_i    (center),
    .interior_i  (interior),
    .rmax_i      (rmax_q),
    .eps_i       (eps),
    .new_val_o   (new_val),
    .rmax_next_o (rmax_next),
    .chg_o       (chg),
    .conv_o      (conv)
  );

  always_comb begin
    rmax_d = rmax_q;
    if (in_fire && emit) begin
      rmax_d = end_sweep ? '0 : rmax_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      rmax_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      rmax_q <= rmax_d;
    end
  end

  // west neighbor = row-above value of the previous column, which was the
  // center of the previous beat in the same row
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      west_q <= center;
    end
  end

  // output register
  logic                      out_valid_q, out_valid_d;
  logic [TEMP_BITS-1:0]      temp_out_q;
  logic [jss_pkg::IDX_W-1:0] row_idx_q, col_idx_q;
  logic                      last_q, conv_q;
  logic [jss_pkg::CHG_W-1:0] chg_q;
  logic [31:0]               row_m1_32;
  logic [31:0]               col_32;

  assign row_m1_32 = 32'(row_q) - 32'd1;
  assign col_32    = 32'(col_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      temp_out_q <= new_val;
      row_idx_q  <= row_m1_32[jss_pkg::IDX_W-1:0];
      col_idx_q  <= col_32[jss_pkg::IDX_W-1:0];
      last_q     <= end_sweep;
      chg_q      <= end_sweep ? chg : '0;
      conv_q     <= end_sweep && conv;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign temp_out_o   = temp_out_q;
  assign row_index_o  = row_idx_q;
  assign col_index_o  = col_idx_q;
  assign sweep_last_o = last_q;
  assign max_change_o = chg_q;
  assign converged_o  = conv_q;

endmodule

### rtl/core/jss_checker.sv
// Port-level checks for jacobi_stencil_sweep, attached by bind.
// Depends on jss_pkg.
`timescale 1ns / 1ps

module jss_checker #(
  parameter int unsigned TEMP_BITS = jss_pkg::TEMP_BITS_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [TEMP_BITS-1:0]      temp_out_o,
  input logic                      sweep_last_o,
  input logic [jss_pkg::CHG_W-1:0] max_change_o,
  input logic                      converged_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temp_out_o)
                                    && $stable(sweep_last_o))
    else $error("stalled result beat changed");

  // an empty output register never stalls the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // summary fields only on the last beat of a sweep
  a_summary_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sweep_last_o |-> (max_change_o == '0) && !converged_o)
    else $error("summary fields set on non-final beat");

  // a max change of zero is below any nonzero tolerance; converged needs
  // a change below epsilon, which the all-ones change can never be
  a_conv_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && converged_o |-> sweep_last_o && (max_change_o != '1))
    else $error("converged flag inconsistent");

  // a cycle spent in reset leaves the output empty
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind jacobi_stencil_sweep jss_checker #(
  .TEMP_BITS (TEMP_BITS)
) u_jss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .temp_out_o   (temp_out_o),
  .sweep_last_o (sweep_last_o),
  .max_change_o (max_change_o),
  .converged_o  (converged_o)
);
